[rtl/sitoa_pkg.sv]
// Package for the signed integer to decimal ASCII converter.
// Holds the controller states, the command and status structs, and the shared constants.
// Depends on nothing.
`timescale 1ns / 1ps

package sitoa_pkg;

   // Reciprocal of ten for a 32-bit dividend: q = (n * RECIP_TEN) >> RECIP_SHIFT
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;
   localparam logic [3:0]  MAX_DIGITS  = 4'd10;
   localparam logic [7:0]  ASCII_ZERO  = 8'h30;
   localparam logic [7:0]  ASCII_MINUS = 8'h2D;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_SIGN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic div;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic neg;
      logic digit_last;
      logic out_free;
   } status_type;

endpackage

[rtl/signed_int_to_decimal_ascii.sv]
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Joins sitoa_ctrl and sitoa_datapath; uses sitoa_pkg.
//
// Usage:
//   Present a signed 32-bit integer on req_value with req_valid high; the item
//   is taken at the clock edge where req_stall is low. The text leaves on the
//   rsp_ channel one character per item: rsp_ascii_char holds '-' or a digit,
//   rsp_position the one-based index and rsp_is_last marks the final character.
//   Negative values start with '-', zero gives a single '0', the most negative
//   value gives -2147483648.
// Timing:
//   Digits are extracted least significant first, each by a reciprocal
//   multiply, then quotient and remainder, and then sent most significant
//   first, one per cycle while the receiver does not stall. A new value is
//   taken once the last character sits in the result register, even while
//   it is still stalled.
// Reset:
//   Synchronous, active high; clears the controller and the result valid.
// Stall:
//   A stalled result holds its payload; the controller waits and extraction
//   state is kept until the receiver takes the character.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_ascii_char,
   output logic [3:0]         rsp_position,
   output logic               rsp_is_last
);

   sitoa_pkg::cmd_type    cmd;
   sitoa_pkg::status_type status;

   // Sequencer: idle, multiply/divide per digit, optional sign, then digits
   sitoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Magnitude, digit store and the result register
   sitoa_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_position   (rsp_position),
      .rsp_is_last    (rsp_is_last)
   );

endmodule

[rtl/sitoa_ctrl.sv]
// Controller for the signed integer to decimal ASCII converter.
// Sequences load, digit extraction and character emission; uses sitoa_pkg.
`timescale 1ns / 1ps

module sitoa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sitoa_pkg::status_type status,
   output sitoa_pkg::cmd_type    cmd
);

   sitoa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sitoa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sitoa_pkg::ST_IDLE: begin
            if (req_valid) state_in = sitoa_pkg::ST_MUL;
         end
         sitoa_pkg::ST_MUL: begin
            state_in = sitoa_pkg::ST_DIV;
         end
         sitoa_pkg::ST_DIV: begin
            if (!status.div_last) begin
               state_in = sitoa_pkg::ST_MUL;
            end else if (status.neg) begin
               state_in = sitoa_pkg::ST_SIGN;
            end else begin
               state_in = sitoa_pkg::ST_EMIT;
            end
         end
         sitoa_pkg::ST_SIGN: begin
            if (status.out_free) state_in = sitoa_pkg::ST_EMIT;
         end
         sitoa_pkg::ST_EMIT: begin
            if (status.out_free && status.digit_last) state_in = sitoa_pkg::ST_IDLE;
         end
         default: begin
            state_in = sitoa_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         sitoa_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         sitoa_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
         end
         sitoa_pkg::ST_DIV: begin
            cmd.div = 1'b1;
         end
         sitoa_pkg::ST_SIGN: begin
            cmd.emit_sign = status.out_free;
         end
         sitoa_pkg::ST_EMIT: begin
            cmd.emit_digit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[rtl/sitoa_datapath.sv]
// Datapath for the signed integer to decimal ASCII converter.
// Magnitude, reciprocal multiply, digit store and result register; uses sitoa_pkg.
`timescale 1ns / 1ps

module sitoa_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic signed [31:0]    req_value,
   input  sitoa_pkg::cmd_type    cmd,
   output sitoa_pkg::status_type status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_ascii_char,
   output logic [3:0]            rsp_position,
   output logic                  rsp_is_last
);

   logic [31:0] mag_ff;
   logic        neg_ff;
   logic [63:0] prod_ff;
   logic [3:0]  digits_ff [10];
   logic [3:0]  nd_ff;
   logic [3:0]  rd_idx_ff;
   logic [3:0]  pos_ff;
   logic        valid_ff, valid_in;
   logic [7:0]  char_ff;
   logic [3:0]  rpos_ff;
   logic        last_ff;

   logic [31:0] quot;
   logic [31:0] rem_full;
   logic [3:0]  pos_next;

   assign quot     = {3'b000, prod_ff[63:sitoa_pkg::RECIP_SHIFT]};
   assign rem_full = mag_ff - ({quot[28:0], 3'b000} + {quot[30:0], 1'b0});
   assign pos_next = pos_ff + 4'd1;

   assign status.div_last   = (quot == 32'd0) || (nd_ff == sitoa_pkg::MAX_DIGITS - 4'd1);
   assign status.neg        = neg_ff;
   assign status.digit_last = (rd_idx_ff == 4'd0);
   assign status.out_free   = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff <= req_value[31];
         mag_ff <= req_value[31] ? (32'd0 - req_value) : req_value;
         nd_ff  <= 4'd0;
         pos_ff <= 4'd0;
      end
      if (cmd.mul) begin
         prod_ff <= {32'd0, mag_ff} * {32'd0, sitoa_pkg::RECIP_TEN};
      end
      if (cmd.div) begin
         digits_ff[nd_ff] <= rem_full[3:0];
         nd_ff            <= nd_ff + 4'd1;
         rd_idx_ff        <= nd_ff;
         mag_ff           <= quot;
      end
      if (cmd.emit_sign) begin
         char_ff <= sitoa_pkg::ASCII_MINUS;
         rpos_ff <= pos_next;
         last_ff <= 1'b0;
         pos_ff  <= pos_next;
      end
      if (cmd.emit_digit) begin
         char_ff   <= sitoa_pkg::ASCII_ZERO + {4'd0, digits_ff[rd_idx_ff]};
         rpos_ff   <= pos_next;
         last_ff   <= (rd_idx_ff == 4'd0);
         pos_ff    <= pos_next;
         rd_idx_ff <= rd_idx_ff - 4'd1;
      end
   end

   // Hold the result while stalled, drop it once taken
   always_comb begin
      if (cmd.emit_sign || cmd.emit_digit) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_position   = rpos_ff;
   assign rsp_is_last    = last_ff;

endmodule

[tb/sv/signed_int_to_decimal_ascii_test.sv]
// Self-checking testbench for signed_int_to_decimal_ascii: directed and random integers in,
// decimal text out, one character per item, checked against an in-bench text predictor.
// Depends on sitoa_pkg (ASCII constants) and the RTL top level only.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_test;

   // Watchdog limit: cycles with no handshake on either channel. The longest
   // legal quiet spell is the receiver hold-off plus a digit extraction
   // and a run of random stalls, so this is several times that.
   localparam int QUIET_LIMIT   = 3000;
   localparam int HOLDOFF_START = 150;   // characters seen before the long hold-off
   localparam int HOLDOFF_LEN   = 150;   // cycles the receiver holds off
   localparam int IDLE_PCT      = 28;
   localparam int RANDOM_ITEMS  = 90;
   localparam int TAIL_CYCLES   = 40;    // settle time after the last character

   // Directed: zero, single digits, digit-count boundaries, both signs,
   // and the extremes including the most negative value.
   localparam int DIRECTED_VALUES[20] = '{
      0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
      12345, -6789, 999999999, 1000000000, -1000000000,
      2147483647, -2147483647, 32'sh8000_0000, 1234567890, -1999999999
   };

   typedef struct {
      logic [7:0] ascii;
      logic [3:0] pos;
      logic       last;
   } text_char_type;

   typedef struct {
      logic [31:0] value;
      bit          drain_first;   // hold this item back until all text has arrived
   } pending_item_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [7:0]         rsp_ascii_char;
   logic [3:0]         rsp_position;
   logic               rsp_is_last;

   pending_item_type pending_items[$];
   text_char_type    expected_chars[$];
   text_char_type    want;
   logic             req_taken = 1'b0;
   int               items_sent = 0;
   int               chars_seen = 0;
   int               mismatches = 0;
   int               quiet_cycles = 0;
   int               holdoff_left = 0;
   bit               holdoff_done = 1'b0;

   signed_int_to_decimal_ascii uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_position   (rsp_position),
      .rsp_is_last    (rsp_is_last)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Build the decimal text of one value and queue its characters in order:
   // optional '-', then digits most significant first, no leading zeros.
   // The magnitude is formed unsigned so the most negative value needs no
   // special handling.
   function automatic void predict_text(input logic [31:0] value);
      logic [31:0] mag;
      logic [3:0]  digit_buf[10];
      int          num_digits;
      int          total;
      int          pos;
      mag = value[31] ? (32'd0 - value) : value;
      num_digits = 0;
      do begin
         digit_buf[num_digits] = 4'(mag % 32'd10);
         num_digits++;
         mag = mag / 32'd10;
      end while (mag != 32'd0);
      total = num_digits + (value[31] ? 1 : 0);
      pos = 0;
      if (value[31]) begin
         pos = 1;
         expected_chars.push_back('{ascii: sitoa_pkg::ASCII_MINUS, pos: 4'd1,
                                    last: (total == 1)});
      end
      for (int i = num_digits - 1; i >= 0; i--) begin
         pos++;
         expected_chars.push_back('{ascii: sitoa_pkg::ASCII_ZERO + 8'(digit_buf[i]),
                                    pos: 4'(pos), last: (pos == total)});
      end
   endfunction

   // Pick a digit count first so short and long texts are equally likely,
   // then a magnitude of that length and a sign; a quarter are raw 32-bit
   // patterns to toggle every bit.
   function automatic logic [31:0] random_value();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mag;
      int          num_digits;
      bit          neg;
      if ($urandom_range(3) == 0) begin
         return $urandom;
      end
      num_digits = $urandom_range(1, 10);
      neg = 1'($urandom_range(1));
      lo = 64'd1;
      repeat (num_digits - 1) lo = lo * 64'd10;
      hi = lo * 64'd10 - 64'd1;
      if (num_digits == 1) begin
         lo = 64'd0;
      end
      if (neg && hi > 64'd2147483648) begin
         hi = 64'd2147483648;
      end else if (!neg && hi > 64'd2147483647) begin
         hi = 64'd2147483647;
      end
      mag = lo + 64'($urandom_range(32'(hi - lo)));
      return neg ? -mag[31:0] : mag[31:0];
   endfunction

   // Count a mismatch; print only the first few in detail.
   function automatic void flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s", msg);
      end
   endfunction

   // Sender: present one item at a time from the pending queue. Hold the
   // payload while it is not taken; idle at random except in a calm stretch
   // of items; pause before a drain-marked item until every character is in.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold: the current item has not been accepted yet
      end else if (pending_items.size() == 0) begin
         req_valid <= 1'b0;
      end else if (pending_items[0].drain_first && expected_chars.size() != 0) begin
         req_valid <= 1'b0;
      end else if (!(items_sent >= 50 && items_sent < 80)
                   && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
      end else begin
         req_value <= pending_items[0].value;
         void'(pending_items.pop_front());
         req_valid <= 1'b1;
         items_sent++;
      end
   end

   // Receiver: stall at random, with a calm stretch of characters and one
   // long hold-off so the block backs up and stalls its input.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_stall <= 1'b1;
      end else if (!holdoff_done && chars_seen >= HOLDOFF_START) begin
         holdoff_done <= 1'b1;
         holdoff_left <= HOLDOFF_LEN - 1;
         rsp_stall <= 1'b1;
      end else if (chars_seen >= 500 && chars_seen < 800) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Monitor: predict on every accepted value, compare every accepted
   // character with the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predict_text(req_value);
         end
         if (rsp_valid && !rsp_stall) begin
            chars_seen++;
            if (expected_chars.size() == 0) begin
               flag_mismatch($sformatf("unexpected char %h pos %0d last %b",
                                       rsp_ascii_char, rsp_position, rsp_is_last));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_ascii_char !== want.ascii || rsp_position !== want.pos
                   || rsp_is_last !== want.last) begin
                  flag_mismatch($sformatf(
                     "char %0d: expected %h pos %0d last %b, got %h pos %0d last %b",
                     chars_seen, want.ascii, want.pos, want.last,
                     rsp_ascii_char, rsp_position, rsp_is_last));
               end
            end
         end
      end
   end

   // Watchdog: drop the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      foreach (DIRECTED_VALUES[i]) begin
         pending_items.push_back('{value: DIRECTED_VALUES[i], drain_first: 1'b0});
      end
      // Random: pause for a full drain at the phase boundary and once midway.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pending_items.push_back('{value: random_value(),
                                   drain_first: (i == 0 || i == 45)});
      end

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_chars.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[files.f]
rtl/sitoa_pkg.sv
rtl/sitoa_ctrl.sv
rtl/sitoa_datapath.sv
rtl/signed_int_to_decimal_ascii.sv
tb/sv/signed_int_to_decimal_ascii_test.sv
